@@ src/brsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rudder steering controller package
// Shared types, register indexes, mode codes and constants.
// ----------------------------------------------------------------------------
package brsc_pkg;

  localparam int FRAC_BITS_DEF = 4;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [1:0] CFG_PROP_GAIN      = 2'd0;
  localparam logic [1:0] CFG_HEADING_GAIN   = 2'd1;
  localparam logic [1:0] CFG_RATE_GAIN      = 2'd2;
  localparam logic [1:0] CFG_TARGET_HEADING = 2'd3;

  localparam logic [1:0] MODE_OFFLINE = 2'd0;
  localparam logic [1:0] MODE_MANUAL  = 2'd1;
  localparam logic [1:0] MODE_AUTO    = 2'd2;

  localparam logic signed [9:0] PROP_GAIN_RST    = -10'sd3;
  localparam logic signed [9:0] HEADING_GAIN_RST = 10'sd3;
  localparam logic signed [9:0] RATE_GAIN_RST    = -10'sd80;
  localparam logic [8:0]        TARGET_RST       = 9'd0;

  localparam int TERM_LIMIT        = 50;
  localparam int SUM_LIMIT         = 100;
  localparam int MANUAL_TIMEOUT_MS = 4000;
  localparam int RATE_SCALE        = 1000;
  localparam int HALF_TURN         = 180;
  localparam int FULL_TURN         = 360;
  localparam int DUTY_GAIN         = 200;
  localparam int DUTY_MAX          = 1024;
  localparam int DEADBAND          = 2;
  localparam int SENSE_FULL        = 1024;
  localparam int SENSE_SPAN        = 200;
  localparam int SENSE_SHIFT       = 10;
  localparam int SENSE_OFFSET      = 100;

  localparam logic signed [7:0] MCMD_MAX = 8'sd100;
  localparam logic signed [7:0] MCMD_MIN = -8'sd100;

  // Rate division: magnitude of a 25-bit difference times 1000.
  localparam int MAG_W     = 34;
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]         op_mode;
    logic               fix_valid;
    logic signed [23:0] cross_track;
    logic [8:0]         course_deg;
    logic [31:0]        now_ms;
    logic               manual_valid;
    logic signed [7:0]  manual_cmd;
    logic [9:0]         rudder_sense;
  } brsc_in_t;

  typedef struct packed {
    logic signed [11:0] rudder_command;
    logic               manual_accepted;
    logic               drive_left;
    logic               drive_right;
    logic [10:0]        drive_duty;
    logic signed [7:0]  sensed_position;
  } brsc_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic rate_upd;
    logic rmul;
    logic sum;
    logic motor;
    logic out_load;
  } brsc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_RATE,
    ST_RMUL,
    ST_SUM,
    ST_MOTOR,
    ST_DONE
  } brsc_state_t;

endpackage
`default_nettype wire

@@ src/boat_rudder_steering_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Boat rudder steering controller
// Each input transaction is one control tick: mode, fix, cross-track error,
// course, time stamp, optional manual command and rudder sensor reading.
// The output transaction carries the rudder setpoint, the manual accept flag,
// the motor direction and duty, and the sensed rudder position.
// An input transaction is accepted only while the block is idle. The result
// lands in the output register after the prepare step, the bit-serial divider
// for the cross-track rate, which resolves one of 34 quotient bits per cycle,
// and the rate, term, sum and drive steps; the next tick can be accepted once
// the block is back in idle.
// While a result waits under out_stall the block still accepts the next tick
// and computes it, then holds in its final step until the register frees up.
// Synchronous reset restores the gain and heading registers to their reset
// values, clears all control state and drops out_valid.
// Configuration writes are taken on any cycle with cfg_we high.
// ----------------------------------------------------------------------------
module boat_rudder_steering_controller import brsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  brsc_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output brsc_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  brsc_cmd_t cmd;

  brsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brsc_dp #(
    .FRAC_BITS (FRAC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ src/brsc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rudder steering controller sequencer
// Steps the datapath through one control tick and owns the output valid.
// ----------------------------------------------------------------------------
module brsc_ctrl import brsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output brsc_cmd_t cmd
);

  brsc_state_t          state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_RATE;
        end
      end
      ST_RATE: begin
        cmd.rate_upd = 1'b1;
        state_next   = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.rmul   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MOTOR;
      end
      ST_MOTOR: begin
        cmd.motor  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ src/brsc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rudder steering controller datapath
// Configuration, control state, serial rate divider, terms and motor drive.
// ----------------------------------------------------------------------------
module brsc_dp import brsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  brsc_in_t   in_data,
  input  brsc_cmd_t  cmd,
  output brsc_out_t  out_data
);

  localparam int SP_W    = FRAC_BITS + 8;
  localparam int SUM_W   = FRAC_BITS + 23;
  localparam int DIFF_W  = SP_W + 1;
  localparam int DPROD_W = SP_W + 8;

  localparam logic signed [33:0] TERM_LIM  = 34'(TERM_LIMIT * (2 ** FRAC_BITS));
  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(SUM_LIMIT * (2 ** FRAC_BITS));
  localparam logic signed [DIFF_W-1:0] DB_LIM = DIFF_W'(DEADBAND * (2 ** FRAC_BITS));
  localparam logic [MAG_W-1:0] RATE_POS_LIM = MAG_W'(32'h7FFF_FFFF);

  logic signed [9:0]      prop_gain, heading_gain, rate_gain;
  logic [8:0]             target_heading;

  logic signed [SP_W-1:0] rudder_setpoint;
  logic signed [23:0]     prev_cross_track;
  logic signed [31:0]     cross_track_rate;
  logic [TIME_BITS-1:0]   last_rate_time, last_manual_time;

  brsc_in_t               tick;
  logic                   ctrl_active, do_div, accepted, neg_rate;
  logic signed [7:0]      sensed;
  logic signed [33:0]     p_prod;
  logic signed [20:0]     h_prod;
  logic signed [41:0]     r_prod;
  logic [MAG_W-1:0]       dq;
  logic [TIME_BITS-1:0]   rem, divisor;
  logic                   drive_left, drive_right;
  logic [DPROD_W-1:0]     duty_prod;

  logic [TIME_BITS-1:0]   now_t, man_elapsed, rate_elapsed;
  logic                   mode_manual, ctrl_act, cmd_ok, man_take, man_expired, div_go;
  logic signed [10:0]     hd, hmag, herr;
  logic signed [24:0]     ct_delta;
  logic signed [34:0]     dprod;
  logic [MAG_W-1:0]       dmag;
  logic [10:0]            sense_span;
  logic [17:0]            sense_scaled;
  logic [TIME_BITS:0]     rem_shift, rem_diff;
  logic                   rem_ge;
  logic signed [31:0]     rate_sat;
  logic signed [33:0]     p_q, r_q34;
  logic signed [41:0]     r_q;
  logic signed [SUM_W-1:0] h_q, p_t, r_t, sum_raw, sum_cl;
  logic signed [DIFF_W-1:0] diff;
  logic [SP_W-1:0]        mag;
  logic [DPROD_W-1:0]     duty_sh;
  logic [10:0]            duty;
  logic [SP_W+11:0]       sp_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      heading_gain   <= HEADING_GAIN_RST;
      rate_gain      <= RATE_GAIN_RST;
      target_heading <= TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:      prop_gain      <= cfg_data;
        CFG_HEADING_GAIN:   heading_gain   <= cfg_data;
        CFG_RATE_GAIN:      rate_gain      <= cfg_data;
        CFG_TARGET_HEADING: target_heading <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    now_t        = tick.now_ms[TIME_BITS-1:0];
    mode_manual  = tick.op_mode == MODE_MANUAL;
    ctrl_act     = (tick.op_mode == MODE_AUTO) && tick.fix_valid;
    cmd_ok       = (tick.manual_cmd >= MCMD_MIN) && (tick.manual_cmd <= MCMD_MAX);
    man_take     = tick.manual_valid && mode_manual && cmd_ok;
    man_elapsed  = now_t - last_manual_time;
    man_expired  = !tick.manual_valid && (man_elapsed > TIME_BITS'(MANUAL_TIMEOUT_MS));
    rate_elapsed = now_t - last_rate_time;
    div_go       = ctrl_act && (tick.cross_track != prev_cross_track) && (rate_elapsed != '0);

    hd   = $signed({2'b00, target_heading}) - $signed({2'b00, tick.course_deg});
    hmag = (hd < 0) ? -hd : hd;
    if (hmag > 11'(HALF_TURN)) begin
      hmag = 11'(FULL_TURN) - hmag;
    end
    herr = ((hd > 11'(HALF_TURN)) || (hd < 0)) ? -hmag : hmag;

    ct_delta = 25'(tick.cross_track) - 25'(prev_cross_track);
    dprod    = 35'(ct_delta) * 35'(RATE_SCALE);
    dmag     = dprod[34] ? MAG_W'(-dprod) : MAG_W'(dprod);

    sense_span   = 11'(SENSE_FULL) - {1'b0, tick.rudder_sense};
    sense_scaled = 18'(sense_span) * 18'(SENSE_SPAN);
  end

  always_comb begin
    rem_shift = {rem, dq[MAG_W-1]};
    rem_ge    = rem_shift >= {1'b0, divisor};
    rem_diff  = rem_shift - {1'b0, divisor};

    if (dq > RATE_POS_LIM) begin
      rate_sat = neg_rate ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rate_sat = neg_rate ? -$signed(dq[31:0]) : $signed(dq[31:0]);
    end
  end

  always_comb begin
    p_q   = p_prod >>> 2;
    r_q   = r_prod >>> 2;
    r_q34 = (r_q > 42'(TERM_LIM)) ? TERM_LIM :
            (r_q < -42'(TERM_LIM)) ? -TERM_LIM : 34'(r_q);
    p_t   = (p_q > TERM_LIM) ? SUM_W'(TERM_LIM) :
            (p_q < -TERM_LIM) ? -SUM_W'(TERM_LIM) : SUM_W'(p_q);
    r_t   = SUM_W'(r_q34);
    h_q   = (SUM_W'(h_prod) <<< FRAC_BITS) >>> 2;
    sum_raw = p_t + r_t + h_q;
    sum_cl  = (sum_raw > SUM_LIM) ? SUM_LIM : (sum_raw < -SUM_LIM) ? -SUM_LIM : sum_raw;

    diff = (DIFF_W'(sensed) <<< FRAC_BITS) - DIFF_W'(rudder_setpoint);
    mag  = (diff < 0) ? SP_W'(-diff) : SP_W'(diff);

    duty_sh = duty_prod >> FRAC_BITS;
    if (!drive_left && !drive_right) begin
      duty = '0;
    end else if (duty_sh > DPROD_W'(DUTY_MAX)) begin
      duty = 11'(DUTY_MAX);
    end else begin
      duty = duty_sh[10:0];
    end
    sp_wide = {{12{rudder_setpoint[SP_W-1]}}, rudder_setpoint};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rudder_setpoint  <= '0;
      prev_cross_track <= '0;
      cross_track_rate <= '0;
      last_rate_time   <= '0;
      last_manual_time <= '0;
    end else begin
      if (cmd.prep) begin
        if (tick.manual_valid) begin
          last_manual_time <= now_t;
        end
        if (ctrl_act) begin
          prev_cross_track <= tick.cross_track;
        end
        if (div_go) begin
          last_rate_time <= now_t;
        end
        if (man_take) begin
          rudder_setpoint <= SP_W'(tick.manual_cmd) <<< FRAC_BITS;
        end else if (mode_manual) begin
          if (man_expired) begin
            rudder_setpoint <= '0;
          end
        end else if (!ctrl_act) begin
          rudder_setpoint <= '0;
        end
      end
      if (cmd.rate_upd && do_div) begin
        cross_track_rate <= rate_sat;
      end
      if (cmd.sum && ctrl_active) begin
        rudder_setpoint <= SP_W'(sum_cl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick <= in_data;
    end
    if (cmd.prep) begin
      ctrl_active <= ctrl_act;
      do_div      <= div_go;
      accepted    <= man_take;
      p_prod      <= 34'(prop_gain) * 34'(tick.cross_track);
      h_prod      <= 21'(heading_gain) * 21'(herr);
      sensed      <= $signed(8'(sense_scaled >> SENSE_SHIFT) - 8'(SENSE_OFFSET));
      divisor     <= rate_elapsed;
      dq          <= dmag;
      rem         <= '0;
      neg_rate    <= dprod[34];
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
      dq  <= {dq[MAG_W-2:0], rem_ge};
    end
    if (cmd.rmul) begin
      r_prod <= 42'(rate_gain) * 42'(cross_track_rate);
    end
    if (cmd.motor) begin
      drive_left  <= diff < -DB_LIM;
      drive_right <= diff > DB_LIM;
      duty_prod   <= DPROD_W'(mag) * DPROD_W'(DUTY_GAIN);
    end
    if (cmd.out_load) begin
      out_data.rudder_command  <= sp_wide[11:0];
      out_data.manual_accepted <= accepted;
      out_data.drive_left      <= drive_left;
      out_data.drive_right     <= drive_right;
      out_data.drive_duty      <= duty;
      out_data.sensed_position <= sensed;
    end
  end

endmodule
`default_nettype wire

@@ src/brsc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rudder steering controller port checker
// Watches the top-level ports for handshake and drive consistency.
// ----------------------------------------------------------------------------
module brsc_port_checker import brsc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input brsc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted while a tick was still in progress.");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.drive_left && out_data.drive_right))
    else $error("Rudder motor driven in both directions.");

  a_deadband_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.drive_left && !out_data.drive_right |->
      out_data.drive_duty == '0)
    else $error("Nonzero duty inside the deadband.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind boat_rudder_steering_controller brsc_port_checker u_checker (.*);
`default_nettype wire
